FILE: design/adams_bashforth_particle_integrator_core_macros.svh
// Assertion macros for the particle integrator core.
`ifndef ADAMS_BASHFORTH_PARTICLE_INTEGRATOR_CORE_MACROS_SVH
`define ADAMS_BASHFORTH_PARTICLE_INTEGRATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ABPI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("abpi: assertion failed");
// next-cycle implication
`define ABPI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("abpi: assertion failed");
`else
`define ABPI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ABPI_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/abpi_pkg.sv
`timescale 1ns / 1ps
package abpi_pkg;

   localparam int NUM_PARTICLES     = 1024;
   localparam int MAX_HISTORY_ORDER = 6;
   localparam int NUM_COMP          = 3;
   localparam int HIST_SLOTS        = 5;
   localparam int NUM_ELEM          = NUM_COMP * NUM_PARTICLES;
   localparam int ELEM_W            = $clog2(NUM_ELEM);
   localparam int RSP_DEPTH         = 16;

   localparam logic CSR_TIME_STEP = 1'b0;
   localparam logic CSR_MAX_ORDER = 1'b1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef struct packed {
      logic               command;
      logic [9:0]         particle;
      logic [1:0]         component;
      logic signed [31:0] sample_value;
      logic               last_of_step;
   } req_payload_type;

   typedef struct packed {
      logic [9:0]         particle_out;
      logic [1:0]         component_out;
      logic signed [31:0] position;
      logic [2:0]         order_used;
   } rsp_payload_type;

   // coefficients over the common denominator 1440, row = order - 1
   localparam logic signed [14:0] COEF_TABLE [6][6] = '{
      '{15'sd1440,  15'sd0,     15'sd0,    15'sd0,     15'sd0,    15'sd0},
      '{15'sd2160, -15'sd720,   15'sd0,    15'sd0,     15'sd0,    15'sd0},
      '{15'sd2760, -15'sd1920,  15'sd600,  15'sd0,     15'sd0,    15'sd0},
      '{15'sd3300, -15'sd3540,  15'sd2220, -15'sd540,  15'sd0,    15'sd0},
      '{15'sd3802, -15'sd5548,  15'sd5232, -15'sd2548, 15'sd502,  15'sd0},
      '{15'sd4277, -15'sd7923,  15'sd9982, -15'sd7298, 15'sd2877, -15'sd475}
   };

   function automatic logic signed [14:0] coef(input logic [2:0] ord, input logic [2:0] idx);
      logic [2:0] row;
      row = ord - 3'd1;
      if (ord == 3'd0 || ord > 3'd6 || idx > 3'd5) begin
         return 15'sd0;
      end
      return COEF_TABLE[row][idx];
   endfunction

endpackage

FILE: design/abpi_req_if.sv
`timescale 1ns / 1ps
interface abpi_req_if;
   logic                      valid;
   logic                      ready;
   abpi_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/abpi_rsp_if.sv
`timescale 1ns / 1ps
interface abpi_rsp_if;
   logic                      valid;
   logic                      ready;
   abpi_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/adams_bashforth_particle_integrator_core.sv
`timescale 1ns / 1ps
// Adams-Bashforth particle integrator (orders 1..6, Q16.16). Takes one request per cycle and
// returns its responses in order through a 16-entry response queue; req ready drops only
// when 16 requests are in flight or queued. Velocity history (5 samples per element) lives in
// one memory read at accept and rewritten in the next cycle; positions live in a second memory
// read and rewritten at the last stage. Each memory forwards its last write to cover the read/write
// overlap, so back-to-back requests to one element are fine. Memories are
// not cleared: load a position before advancing it. Requests with component 3 get no response.
`include "adams_bashforth_particle_integrator_core_macros.svh"
module adams_bashforth_particle_integrator_core (
   input  logic        clock,
   input  logic        reset,
   abpi_req_if.sink    req_chan,
   abpi_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam int EW    = abpi_pkg::ELEM_W;
   localparam int NS    = 9;
   localparam int QAW   = $clog2(abpi_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(abpi_pkg::RSP_DEPTH + 1);
   localparam int HW    = 32 * abpi_pkg::HIST_SLOTS;

   typedef struct packed {
      logic               cmd;
      logic [9:0]         part;
      logic [1:0]         comp;
      logic signed [31:0] val;
      logic [2:0]         ord;
      logic [EW-1:0]      elem;
   } ctl_type;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [38:0] x;
      logic [5:0]  rem;
      logic [38:0] quo;
   } div_type;

   // one long-division digit by 45: 13 bits of quotient per step
   function automatic logic [18:0] div45(input logic [5:0] rem, input logic [12:0] chunk);
      logic [18:0] rr;
      logic [38:0] prod;
      logic [12:0] q;
      logic [18:0] r;
      rr   = {rem, chunk};
      prod = 39'(rr) * 39'd745655;
      q    = prod[37:25];
      r    = rr - 19'(q) * 19'd45;
      return {q, r[5:0]};
   endfunction

   // configuration and step count
   logic [31:0] time_step_ff;
   logic [2:0]  max_order_ff;
   logic [2:0]  steps_done_ff;

   // pipeline control
   logic [NS:1] vld_ff;
   ctl_type     ctl_ff [1:NS];

   logic [HW-1:0] hist_mem [abpi_pkg::NUM_ELEM];
   logic [HW-1:0] hist_q_ff;
   logic [HW-1:0] hfwd_ff;
   logic [EW-1:0] hfwd_elem_ff;
   logic          hfwd_vld_ff;

   logic signed [31:0] pos_mem [abpi_pkg::NUM_ELEM];
   logic signed [31:0] pos_q_ff;
   logic signed [31:0] pfwd_ff;
   logic [EW-1:0]      pfwd_elem_ff;
   logic               pfwd_vld_ff;

   logic signed [46:0] prod_ff [6];
   logic signed [47:0] sum_ff;
   logic [46:0]        mag_ff;
   logic               neg4_ff, neg5_ff;
   logic [54:0]        pl_ff;
   logic [55:0]        ph_ff;
   div_type            div_ff [6:NS];

   abpi_pkg::rsp_payload_type rsp_mem [abpi_pkg::RSP_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] occ_ff, cnt_ff;

   // accept side
   abpi_pkg::req_payload_type rq;
   logic          accept, in_range;
   logic [EW-1:0] req_elem;
   logic [2:0]    lim;
   logic [3:0]    nxt;
   logic [2:0]    ord_in;

   assign rq       = req_chan.payload;
   assign req_chan.ready = cnt_ff < CNT_W'(abpi_pkg::RSP_DEPTH);
   assign accept   = req_chan.valid && req_chan.ready;
   assign in_range = (rq.component != 2'd3) && (32'(rq.particle) < abpi_pkg::NUM_PARTICLES);
   assign req_elem = EW'(EW'({rq.particle, 1'b0}) + EW'(rq.particle) + EW'(rq.component));

   always_comb begin
      if (max_order_ff == 3'd0) begin
         lim = 3'd1;
      end else if (32'(max_order_ff) > abpi_pkg::MAX_HISTORY_ORDER) begin
         lim = 3'(abpi_pkg::MAX_HISTORY_ORDER);
      end else begin
         lim = max_order_ff;
      end
      nxt    = {1'b0, steps_done_ff} + 4'd1;
      ord_in = (nxt < {1'b0, lim}) ? nxt[2:0] : lim;
   end

   // stage 1: history select, update, products
   logic [HW-1:0]      hist_sel, hist_new;
   logic signed [46:0] prod_in [6];
   logic signed [31:0] v_w;

   always_comb begin
      hist_sel = (hfwd_vld_ff && hfwd_elem_ff == ctl_ff[1].elem) ? hfwd_ff : hist_q_ff;
      hist_new = {hist_sel[HW-33:0], ctl_ff[1].val};
      for (int i = 0; i < 6; i++) begin
         if (i == 0) begin
            v_w = ctl_ff[1].val;
         end else if (3'(i) < ctl_ff[1].ord) begin
            v_w = hist_sel[32*(i-1) +: 32];
         end else begin
            v_w = 32'sd0;
         end
         prod_in[i] = 47'(abpi_pkg::coef(ctl_ff[1].ord, 3'(i))) * 47'(v_w);
      end
   end

   // stage 2..5 arithmetic
   logic signed [47:0] sum_in;
   logic [78:0]        full;
   div_type            div6_in;

   always_comb begin
      sum_in = 48'sd0;
      for (int i = 0; i < 6; i++) begin
         sum_in = sum_in + 48'(prod_ff[i]);
      end
      full = (79'(ph_ff) << 23) + 79'(pl_ff);
      div6_in.neg = neg5_ff;
      div6_in.sat = |full[78:60];
      div6_in.x   = full[59:21];
      div6_in.rem = 6'd0;
      div6_in.quo = 39'd0;
   end

   // division steps
   div_type     div_in [7:NS];
   logic [18:0] dstep  [7:NS];

   always_comb begin
      for (int s = 7; s <= NS; s++) begin
         dstep[s]      = div45(div_ff[s-1].rem, div_ff[s-1].x[38-13*(s-7) -: 13]);
         div_in[s]     = div_ff[s-1];
         div_in[s].rem = dstep[s][5:0];
         div_in[s].quo = {div_ff[s-1].quo[25:0], dstep[s][18:6]};
      end
   end

   // last stage: position update
   logic signed [31:0] pos_old, pos_new;
   logic signed [40:0] pos_sum;
   abpi_pkg::rsp_payload_type rsp_in;

   always_comb begin
      pos_old = (pfwd_vld_ff && pfwd_elem_ff == ctl_ff[NS].elem) ? pfwd_ff : pos_q_ff;
      if (div_ff[NS].neg) begin
         pos_sum = 41'(pos_old) - $signed({2'b00, div_ff[NS].quo});
      end else begin
         pos_sum = 41'(pos_old) + $signed({2'b00, div_ff[NS].quo});
      end
      if (ctl_ff[NS].cmd == abpi_pkg::CMD_LOAD) begin
         pos_new = ctl_ff[NS].val;
      end else if (div_ff[NS].sat) begin
         pos_new = div_ff[NS].neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (pos_sum > 41'sh0_7fff_ffff) begin
         pos_new = 32'sh7fff_ffff;
      end else if (pos_sum < -41'sh0_8000_0000) begin
         pos_new = 32'sh8000_0000;
      end else begin
         pos_new = pos_sum[31:0];
      end
      rsp_in.particle_out  = ctl_ff[NS].part;
      rsp_in.component_out = ctl_ff[NS].comp;
      rsp_in.position      = pos_new;
      rsp_in.order_used    = (ctl_ff[NS].cmd == abpi_pkg::CMD_ADVANCE) ? ctl_ff[NS].ord : 3'd1;
   end

   // response queue and credit
   logic             rsp_pop, push;
   logic [CNT_W-1:0] cnt_in, occ_in;

   assign rsp_chan.valid   = occ_ff != '0;
   assign rsp_chan.payload = rsp_mem[rd_ptr_ff];
   assign rsp_pop          = rsp_chan.valid && rsp_chan.ready;
   assign push             = vld_ff[NS];
   assign cnt_in = cnt_ff + CNT_W'(accept && in_range) - CNT_W'(rsp_pop);
   assign occ_in = occ_ff + CNT_W'(push) - CNT_W'(rsp_pop);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= '0;
         max_order_ff  <= 3'd1;
         steps_done_ff <= '0;
         vld_ff        <= '0;
         hfwd_vld_ff   <= 1'b0;
         pfwd_vld_ff   <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         occ_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               abpi_pkg::CSR_TIME_STEP: time_step_ff <= csr_wr_data;
               abpi_pkg::CSR_MAX_ORDER: max_order_ff <= csr_wr_data[2:0];
            endcase
         end
         if (accept && rq.command == abpi_pkg::CMD_ADVANCE && rq.last_of_step &&
             steps_done_ff != 3'd7) begin
            steps_done_ff <= steps_done_ff + 3'd1;
         end
         vld_ff      <= {vld_ff[NS-1:1], accept && in_range};
         hfwd_vld_ff <= vld_ff[1] && ctl_ff[1].cmd == abpi_pkg::CMD_ADVANCE;
         pfwd_vld_ff <= vld_ff[NS];
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         occ_ff <= occ_in;
         cnt_ff <= cnt_in;
      end
   end

   // datapath and memories
   always_ff @(posedge clock) begin
      ctl_ff[1] <= '{cmd: rq.command, part: rq.particle, comp: rq.component,
                     val: rq.sample_value, ord: ord_in, elem: req_elem};
      for (int s = 2; s <= NS; s++) begin
         ctl_ff[s] <= ctl_ff[s-1];
      end
      hist_q_ff <= hist_mem[req_elem];
      if (vld_ff[1] && ctl_ff[1].cmd == abpi_pkg::CMD_ADVANCE) begin
         hist_mem[ctl_ff[1].elem] <= hist_new;
      end
      hfwd_ff      <= hist_new;
      hfwd_elem_ff <= ctl_ff[1].elem;
      for (int i = 0; i < 6; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      sum_ff  <= sum_in;
      mag_ff  <= 47'(sum_ff[47] ? -sum_ff : sum_ff);
      neg4_ff <= sum_ff[47];
      pl_ff   <= 55'(mag_ff[22:0]) * 55'(time_step_ff);
      ph_ff   <= 56'(mag_ff[46:23]) * 56'(time_step_ff);
      neg5_ff <= neg4_ff;
      div_ff[6] <= div6_in;
      for (int s = 7; s <= NS; s++) begin
         div_ff[s] <= div_in[s];
      end
      pos_q_ff <= pos_mem[ctl_ff[NS-1].elem];
      if (vld_ff[NS]) begin
         pos_mem[ctl_ff[NS].elem] <= pos_new;
      end
      pfwd_ff      <= pos_new;
      pfwd_elem_ff <= ctl_ff[NS].elem;
      if (push) begin
         rsp_mem[wr_ptr_ff] <= rsp_in;
      end
   end

   `ABPI_ASSERT_IMP(a_credit_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(abpi_pkg::RSP_DEPTH))
   `ABPI_ASSERT_IMP(a_queue_le_credit, clock, reset, 1'b1, occ_ff <= cnt_ff)
   `ABPI_ASSERT_IMP(a_no_push_when_full, clock, reset, push, occ_ff < CNT_W'(abpi_pkg::RSP_DEPTH))
   `ABPI_ASSERT_IMP(a_order_range, clock, reset, vld_ff[NS], (ctl_ff[NS].ord != 3'd0) && (ctl_ff[NS].ord <= 3'd6))
   `ABPI_ASSERT_NXT(a_step_count, clock, reset, accept && rq.command && rq.last_of_step && (steps_done_ff != 3'd7), steps_done_ff == $past(steps_done_ff) + 3'd1)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import abpi_pkg::*;

   localparam int     LATENCY       = 40;
   localparam int     WATCHDOG_MAX  = 4000;
   localparam int     POOL_SIZE     = 30;
   localparam longint DT_DENOM      = 64'd94371840;

   // coefficients over the common denominator 1440, row = order - 1
   localparam int AB_COEF [6][6] = '{
      '{1440,     0,    0,     0,    0,    0},
      '{2160,  -720,    0,     0,    0,    0},
      '{2760, -1920,  600,     0,    0,    0},
      '{3300, -3540, 2220,  -540,    0,    0},
      '{3802, -5548, 5232, -2548,  502,    0},
      '{4277, -7923, 9982, -7298, 2877, -475}
   };

   function automatic int order_limit(input int mo);
      if (mo < 1) return 1;
      if (mo > MAX_HISTORY_ORDER) return MAX_HISTORY_ORDER;
      return mo;
   endfunction

   class integrator_scoreboard;
      int              position_mem [NUM_ELEM];
      int              velocity_hist [NUM_ELEM][HIST_SLOTS];
      int              step_count;
      bit [31:0]       dt;
      int              max_ord;
      rsp_payload_type expected_positions [$];
      int              mismatches;
      int              requests_seen;
      int              responses_seen;

      function new();
         step_count = 0;
         dt         = 0;
         max_ord    = 1;
         mismatches = 0;
      endfunction

      function automatic longint advance_position(input int e, input int v, input int ord);
         longint     s;
         logic [63:0]  mag;
         logic [127:0] prod;
         longint     q;
         longint     p;
         s = longint'(AB_COEF[ord-1][0]) * longint'(v);
         for (int i = 1; i < ord; i++)
            s += longint'(AB_COEF[ord-1][i]) * longint'(velocity_hist[e][i-1]);
         mag  = (s < 0) ? -s : s;
         prod = {64'd0, mag} * {96'd0, dt};
         q    = longint'(prod / DT_DENOM);
         if (q > (64'd1 << 40)) q = 64'd1 << 40;
         p = longint'(position_mem[e]) + ((s < 0) ? -q : q);
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         if (p < -64'sd2147483648) p = -64'sd2147483648;
         return p;
      endfunction

      function void note_request(input req_payload_type r);
         int              e;
         int              ord;
         rsp_payload_type x;
         requests_seen++;
         ord = step_count + 1;
         if (ord > order_limit(max_ord)) ord = order_limit(max_ord);
         if (r.command == CMD_ADVANCE && r.last_of_step && step_count < 7) step_count++;
         if (r.component > 2) return;
         e = r.particle * NUM_COMP + r.component;
         x.particle_out  = r.particle;
         x.component_out = r.component;
         if (r.command == CMD_LOAD) begin
            position_mem[e] = r.sample_value;
            x.position      = r.sample_value;
            x.order_used    = 3'd1;
         end else begin
            position_mem[e] = int'(advance_position(e, r.sample_value, ord));
            for (int i = HIST_SLOTS - 1; i > 0; i--)
               velocity_hist[e][i] = velocity_hist[e][i-1];
            velocity_hist[e][0] = r.sample_value;
            x.position      = position_mem[e];
            x.order_used    = 3'(ord);
         end
         expected_positions.push_back(x);
      endfunction

      function void check_response(input rsp_payload_type a);
         rsp_payload_type x;
         responses_seen++;
         if (expected_positions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response p=%0d c=%0d pos=%h ord=%0d", $time,
                        a.particle_out, a.component_out, a.position, a.order_used);
            return;
         end
         x = expected_positions.pop_front();
         if (a !== x) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp p=%0d c=%0d pos=%h ord=%0d, got p=%0d c=%0d pos=%h ord=%0d",
                        $time, x.particle_out, x.component_out, x.position, x.order_used,
                        a.particle_out, a.component_out, a.position, a.order_used);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [31:0] csr_wr_data;

   abpi_req_if req_chan ();
   abpi_rsp_if rsp_chan ();

   adams_bashforth_particle_integrator_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   integrator_scoreboard sb;

   int tx_idle;
   int rx_idle;
   bit hold_request;
   int hold_left;
   int idle_cycles;

   // stimulus-side view of the block, kept in generation order
   int gen_steps;
   int gen_max_ord;
   int gen_hist [NUM_ELEM];
   bit gen_loaded [NUM_ELEM];
   int pool [POOL_SIZE];
   int loads_sent;
   int advances_sent;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // receiver: random stalls, plus a long hold when asked
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = 300;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) sb.check_response(rsp_chan.payload);
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Watchdog: no traffic for %0d cycles", WATCHDOG_MAX);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      if (idx == CSR_TIME_STEP) sb.dt = data;
      else begin
         sb.max_ord  = int'(data[2:0]);
         gen_max_ord = int'(data[2:0]);
      end
   endtask

   task automatic send_request(input req_payload_type r);
      int e;
      if (r.command == CMD_ADVANCE && r.last_of_step && gen_steps < 7) gen_steps++;
      if (r.component <= 2) begin
         e = r.particle * NUM_COMP + r.component;
         if (r.command == CMD_LOAD) begin
            gen_loaded[e] = 1'b1;
            loads_sent++;
         end else begin
            if (gen_hist[e] < HIST_SLOTS) gen_hist[e]++;
            advances_sent++;
         end
      end
      while ($urandom_range(99) < tx_idle) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.payload = r;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic send_fields(input logic cmd, input int part, input int comp,
                              input logic [31:0] val, input logic last);
      req_payload_type r;
      r.command      = cmd;
      r.particle     = 10'(part);
      r.component    = 2'(comp);
      r.sample_value = val;
      r.last_of_step = last;
      send_request(r);
   endtask

   task automatic drain;
      while (sb.expected_positions.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_velocity();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return $urandom_range(32'h0003_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_request;
      int   e;
      int   need;
      int   sel;
      logic last;
      sel  = $urandom_range(99);
      last = ($urandom_range(19) == 0);
      need = gen_steps + 1;
      if (need > order_limit(gen_max_ord)) need = order_limit(gen_max_ord);
      if (sel < 8) begin
         send_fields(1'($urandom_range(1)), $urandom_range(1023), 3, $urandom,
                     1'($urandom_range(1)));
      end else if (sel < 25) begin
         send_fields(CMD_LOAD, $urandom_range(1023), $urandom_range(2), $urandom, last);
      end else begin
         if ($urandom_range(9) < 3) e = $urandom_range(NUM_ELEM - 1);
         else e = pool[$urandom_range(POOL_SIZE - 1)];
         if (!gen_loaded[e])
            send_fields(CMD_LOAD, e / NUM_COMP, e % NUM_COMP, pick_velocity(), last);
         else begin
            // history must cover the order in use
            if (gen_hist[e] < need - 1) e = pool[$urandom_range(POOL_SIZE - 1)];
            send_fields(CMD_ADVANCE, e / NUM_COMP, e % NUM_COMP, pick_velocity(), last);
         end
      end
   endtask

   task automatic run_phase(input logic [31:0] dt, input logic [2:0] mo,
                            input int tx, input int rx, input int count, input bit squeeze);
      drain();
      write_csr(CSR_TIME_STEP, dt);
      write_csr(CSR_MAX_ORDER, {29'd0, mo});
      tx_idle = tx;
      rx_idle = rx;
      if (squeeze) hold_request = 1'b1;
      repeat (count) random_request();
   endtask

   initial begin
      sb            = new();
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_TIME_STEP;
      csr_wr_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      tx_idle       = 0;
      rx_idle       = 0;
      hold_request  = 1'b0;
      hold_left     = 0;
      idle_cycles   = 0;
      gen_steps     = 0;
      gen_max_ord   = 1;
      loads_sent    = 0;
      advances_sent = 0;
      for (int i = 0; i < NUM_ELEM; i++) begin
         gen_hist[i]   = 0;
         gen_loaded[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, saturation, out-of-range component, step marker
      write_csr(CSR_TIME_STEP, 32'hFFFF_FFFF);
      write_csr(CSR_MAX_ORDER, 32'd6);
      send_fields(CMD_LOAD, 0, 0, 32'h7FFF_FFFF, 1'b0);
      send_fields(CMD_LOAD, 0, 1, 32'h8000_0000, 1'b0);
      send_fields(CMD_LOAD, 1023, 2, 32'h0000_0000, 1'b0);
      send_fields(CMD_LOAD, 1023, 0, 32'hFFFF_FFFB, 1'b0);
      send_fields(CMD_ADVANCE, 0, 0, 32'h7FFF_FFFF, 1'b0);
      send_fields(CMD_ADVANCE, 0, 1, 32'h8000_0000, 1'b0);
      send_fields(CMD_ADVANCE, 1023, 2, 32'h0001_0000, 1'b0);
      send_fields(CMD_ADVANCE, 1023, 0, 32'hFFFF_FFFF, 1'b0);
      send_fields(CMD_ADVANCE, 5, 3, 32'h1234_5678, 1'b0);
      send_fields(CMD_LOAD, 1023, 3, 32'hFFFF_FFFF, 1'b1);
      send_fields(CMD_ADVANCE, 1023, 3, 32'h0, 1'b1);
      send_fields(CMD_ADVANCE, 0, 0, 32'hFFFF_0000, 1'b0);
      send_fields(CMD_ADVANCE, 1023, 2, 32'h0, 1'b1);
      send_fields(CMD_ADVANCE, 0, 0, 32'h8000_0000, 1'b0);
      send_fields(CMD_LOAD, 512, 1, 32'h0123_4567, 1'b1);

      // fill the history of a working set at order 1 (max order 0 acts as 1)
      drain();
      write_csr(CSR_TIME_STEP, 32'h0001_0000);
      write_csr(CSR_MAX_ORDER, 32'd0);
      pool[0] = 0;
      pool[1] = NUM_ELEM - 1;
      for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom_range(NUM_ELEM - 1);
      for (int i = 0; i < POOL_SIZE; i++)
         send_fields(CMD_LOAD, pool[i] / NUM_COMP, pool[i] % NUM_COMP, $urandom, 1'b0);
      for (int k = 0; k < HIST_SLOTS; k++)
         for (int i = 0; i < POOL_SIZE; i++)
            send_fields(CMD_ADVANCE, pool[i] / NUM_COMP, pool[i] % NUM_COMP,
                        pick_velocity(), 1'b0);

      run_phase(32'h0000_8000, 3'd7, 7, 80, 360, 1'b0);
      run_phase($urandom, 3'd3, 80, 7, 360, 1'b0);
      run_phase(32'h0000_0000, 3'd6, 0, 0, 360, 1'b1);
      run_phase(32'hFFFF_FFFF, 3'd2, 0, 0, 200, 1'b0);
      run_phase(32'h0000_0100, 3'd6, 0, 0, 160, 1'b0);
      drain();

      $display("Covered %0d requests (%0d loads, %0d advances), %0d responses checked",
               sb.requests_seen, loads_sent, advances_sent, sb.responses_seen);
      $display("Orders 1..6 with max order 0..7, dt from 0 to full scale, saturation, stalls");
      if (sb.mismatches == 0 && sb.expected_positions.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", sb.mismatches,
                  sb.expected_positions.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/abpi_pkg.sv
design/abpi_req_if.sv
design/abpi_rsp_if.sv
design/adams_bashforth_particle_integrator_core.sv
tb/tb_top.sv
